[rtl/tfp_pkg.sv]
// Shared types and constants for the telemetry frame packer.
`default_nettype none
package tfp_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_WORD    = 2'd0;
  localparam logic [1:0] REG_TASK_COUNT   = 2'd1;
  localparam logic [1:0] REG_MODE_SAFE    = 2'd2;
  localparam logic [1:0] REG_MODE_NOMINAL = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Body length codes (byte count minus one)
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_4 = 2'd3;

  // Command queue depth
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // One emit command: what the back end sends for one slot value
  typedef struct packed {
    logic        first;     // frame head: sync, sequence, then data
    logic        last;      // append checksum after the body
    logic [1:0]  bytes_m1;  // body bytes minus one, when not first
    logic [31:0] seq;       // frame sequence for the head
    logic [31:0] data;      // slot value already mapped, clamped or masked
  } cmd_t;

endpackage
`default_nettype wire

[rtl/tfp_front.sv]
// Slot tracker and classifier: turns accepted words into emit commands.
`default_nettype none
module tfp_front #(
  parameter int TASK_SLOTS   = 8,
  parameter int SENSOR_SLOTS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          kind,
  input  wire logic [31:0]   value,
  input  wire logic          value_valid,
  input  wire logic [3:0]    task_count,
  input  wire logic [7:0]    mode_code_safe,
  input  wire logic [7:0]    mode_code_nominal,
  input  wire logic          q_full,
  output logic               push,
  output tfp_pkg::cmd_t      cmd
);
  import tfp_pkg::*;

  localparam int SL_UPTIME  = 0;
  localparam int SL_FRAMES  = 1;
  localparam int SL_FOVR    = 2;
  localparam int SL_SLACK   = 3;
  localparam int SL_TASK0   = 4;
  localparam int SL_REPAIRS = SL_TASK0 + TASK_SLOTS;
  localparam int SL_SHORT   = SL_REPAIRS + 4;
  localparam int SL_MODE    = SL_SHORT + 1;
  localparam int SL_REASON  = SL_SHORT + 2;
  localparam int SL_CAUSE   = SL_SHORT + 3;
  localparam int SL_FLAGS   = SL_SHORT + 4;
  localparam int SL_SENSOR0 = SL_SHORT + 5;
  localparam int SL_TOTAL   = SL_SENSOR0 + SENSOR_SLOTS;
  localparam int SW         = $clog2(SL_TOTAL);

  logic [SW-1:0] slot_index;
  logic [31:0]   frame_sequence;
  logic [SW-1:0] task_idx;
  logic [15:0]   clamp16;
  logic [7:0]    clamp8;
  logic          accept;
  logic          slot_last;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && !kind;
  assign slot_last = (slot_index == SW'(SL_TOTAL - 1));
  assign task_idx  = slot_index - SW'(SL_TASK0);
  assign clamp16   = (|value[31:16]) ? 16'hFFFF : value[15:0];
  assign clamp8    = (|value[31:8]) ? 8'hFF : value[7:0];

  always_comb begin
    cmd          = '0;
    cmd.seq      = frame_sequence;
    cmd.last     = slot_last;
    priority if (slot_index == SW'(SL_UPTIME)) begin
      cmd.first    = 1'b1;
      cmd.bytes_m1 = LEN_4;
      cmd.data     = value_valid ? value : 32'hFFFF_FFFF;
    end else if (slot_index == SW'(SL_FRAMES)) begin
      cmd.bytes_m1 = LEN_4;
      cmd.data     = value;
    end else if (slot_index == SW'(SL_FOVR) || slot_index == SW'(SL_SLACK)) begin
      cmd.bytes_m1 = LEN_2;
      cmd.data     = {16'd0, clamp16};
    end else if (slot_index < SW'(SL_REPAIRS)) begin
      // Task overrun bytes; dead tasks send zero
      cmd.bytes_m1 = LEN_1;
      cmd.data     = (task_idx < SW'(task_count)) ? {24'd0, clamp8} : 32'd0;
    end else if (slot_index < SW'(SL_SHORT)) begin
      cmd.bytes_m1 = LEN_2;
      cmd.data     = {16'd0, clamp16};
    end else if (slot_index == SW'(SL_SHORT)) begin
      cmd.bytes_m1 = LEN_1;
      cmd.data     = {24'd0, clamp8};
    end else if (slot_index == SW'(SL_MODE)) begin
      cmd.bytes_m1 = LEN_1;
      cmd.data     = {24'd0, (value != 32'd0) ? mode_code_safe : mode_code_nominal};
    end else if (slot_index == SW'(SL_REASON) || slot_index == SW'(SL_CAUSE) ||
                 slot_index == SW'(SL_FLAGS)) begin
      cmd.bytes_m1 = LEN_1;
      cmd.data     = {24'd0, value[7:0]};
    end else begin
      cmd.bytes_m1 = LEN_2;
      cmd.data     = {16'd0, value[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index     <= '0;
      frame_sequence <= '0;
    end else if (accept) begin
      if (kind) begin
        slot_index     <= '0;
        frame_sequence <= '0;
      end else if (slot_last) begin
        slot_index     <= '0;
        frame_sequence <= frame_sequence + 32'd1;
      end else begin
        slot_index <= slot_index + SW'(1);
      end
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_index <= SW'(SL_TOTAL - 1))
    else $error("slot index past end of layout");

endmodule
`default_nettype wire

[rtl/tfp_queue.sv]
// Short command queue between the classifier and the byte emitter.
`default_nettype none
module tfp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tfp_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output tfp_pkg::cmd_t      head_cmd
);
  import tfp_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full       = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_PTR_W + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[rtl/tfp_back.sv]
// Byte emitter: serializes commands, keeps the running checksum.
`default_nettype none
module tfp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [31:0]   sync_word,
  input  wire logic          head_valid,
  input  wire tfp_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         frame_byte,
  output logic               last_of_frame
);
  import tfp_pkg::*;

  typedef enum logic [1:0] {
    PH_BODY,
    PH_CK_LO,
    PH_CK_HI
  } phase_t;

  phase_t      phase;
  logic [3:0]  byte_idx;
  logic [15:0] sum_accumulator;

  logic        load;
  logic        body_done;
  logic [3:0]  body_end;
  logic [95:0] body_word;
  logic [7:0]  body_byte;
  logic [15:0] sum_base;
  logic [16:0] sum_wide;
  logic [15:0] sum_next;

  assign load      = head_valid && (!out_valid || out_ready);
  assign body_end  = head_cmd.first ? 4'd11 : {2'b00, head_cmd.bytes_m1};
  assign body_done = (byte_idx == body_end);
  assign body_word = head_cmd.first ? {head_cmd.data, head_cmd.seq, sync_word}
                                    : {64'd0, head_cmd.data};
  assign body_byte = body_word[{byte_idx, 3'b000} +: 8];

  // Frame head restarts the sum
  assign sum_base  = (head_cmd.first && byte_idx == 4'd0) ? 16'd0 : sum_accumulator;
  assign sum_wide  = {1'b0, sum_base} + {9'd0, body_byte};
  assign sum_next  = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    pop = 1'b0;
    if (load) begin
      unique case (phase)
        PH_BODY:  pop = body_done && !head_cmd.last;
        PH_CK_LO: pop = 1'b0;
        PH_CK_HI: pop = 1'b1;
        default:  pop = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BODY;
      byte_idx        <= '0;
      sum_accumulator <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        unique case (phase)
          PH_BODY: begin
            frame_byte      <= body_byte;
            last_of_frame   <= 1'b0;
            sum_accumulator <= sum_next;
            if (body_done) begin
              byte_idx <= '0;
              if (head_cmd.last) begin
                phase <= PH_CK_LO;
              end
            end else begin
              byte_idx <= byte_idx + 4'd1;
            end
          end
          PH_CK_LO: begin
            frame_byte    <= ~sum_accumulator[7:0];
            last_of_frame <= 1'b0;
            phase         <= PH_CK_HI;
          end
          PH_CK_HI: begin
            frame_byte      <= ~sum_accumulator[15:8];
            last_of_frame   <= 1'b1;
            sum_accumulator <= '0;
            phase           <= PH_BODY;
          end
          default: phase <= PH_BODY;
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_ck_holds_cmd: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BODY) |-> head_valid)
    else $error("checksum phase without its command");

  a_ck_only_last: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CK_LO) |-> head_cmd.last)
    else $error("checksum started for a non-final slot");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> byte_idx <= body_end)
    else $error("byte index past body end");

endmodule
`default_nettype wire

[rtl/telemetry_frame_packer.sv]
// Top level of the telemetry frame packer: config registers and the two halves.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  in       | in_valid / in_ready      | kind, value, value_valid
//  out      | out_valid / out_ready    | frame_byte, last_of_frame
//  config   | cfg_we (no wait)         | cfg_index, cfg_wdata
//
// Output: the byte emitter puts out one byte per cycle while out_ready is high;
// a word gives 1, 2 or 4 bytes, 12 for the uptime word (sync, sequence,
// uptime), plus 2 checksum bytes after the last sensor word.
// The front takes one word per cycle until the 4-entry command queue fills.
// Reset: synchronous, active high; clears slot, sequence, sum and queue, sets config to its defaults.
// Stalls: out_ready low holds the output byte; the queue absorbs input bursts.
`default_nettype none
module telemetry_frame_packer #(
  parameter int TASK_SLOTS   = 8,
  parameter int SENSOR_SLOTS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               kind,
  input  wire logic [31:0]                        value,
  input  wire logic                               value_valid,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              frame_byte,
  output logic                                    last_of_frame,
  input  wire logic                               cfg_we,
  input  wire logic [tfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [tfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tfp_pkg::*;

  // Configuration registers
  logic [31:0] sync_word;
  logic [3:0]  task_count;
  logic [7:0]  mode_code_safe;
  logic [7:0]  mode_code_nominal;

  // Front to queue, queue to back
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_push_cmd;
  cmd_t q_head_cmd;

  // Latch config words; the user must write only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word         <= 32'd0;
      task_count        <= 4'd8;
      mode_code_safe    <= 8'd1;
      mode_code_nominal <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_WORD:    sync_word         <= cfg_wdata;
        REG_TASK_COUNT:   task_count        <= cfg_wdata[3:0];
        REG_MODE_SAFE:    mode_code_safe    <= cfg_wdata[7:0];
        REG_MODE_NOMINAL: mode_code_nominal <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Classify each word by its slot and queue an emit command
  tfp_front #(
    .TASK_SLOTS   (TASK_SLOTS),
    .SENSOR_SLOTS (SENSOR_SLOTS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .value             (value),
    .value_valid       (value_valid),
    .task_count        (task_count),
    .mode_code_safe    (mode_code_safe),
    .mode_code_nominal (mode_code_nominal),
    .q_full            (q_full),
    .push              (q_push),
    .cmd               (q_push_cmd)
  );

  // Decouple classification from byte serialization
  tfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // Drain commands one byte per cycle while out_ready is high, append the checksum at frame end
  tfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .sync_word     (sync_word),
    .head_valid    (q_head_valid),
    .head_cmd      (q_head_cmd),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for telemetry_frame_packer: random slot words, byte scoreboard, stalls.
module tb;
  import tfp_pkg::*;

  // Frame layout, in slot order, for the default parameters of the block
  localparam int TASK_SLOTS   = 8;
  localparam int SENSOR_SLOTS = 8;
  localparam int SLOT_UPTIME  = 0;
  localparam int SLOT_FRAMES  = 1;
  localparam int SLOT_FOVR    = 2;
  localparam int SLOT_SLACK   = 3;
  localparam int SLOT_TASK0   = 4;
  localparam int SLOT_REPAIRS = SLOT_TASK0 + TASK_SLOTS;
  localparam int SLOT_SHORT   = SLOT_REPAIRS + 4;
  localparam int SLOT_MODE    = SLOT_SHORT + 1;
  localparam int SLOT_REASON  = SLOT_SHORT + 2;
  localparam int SLOT_CAUSE   = SLOT_SHORT + 3;
  localparam int SLOT_FLAGS   = SLOT_SHORT + 4;
  localparam int SLOT_SENSOR0 = SLOT_SHORT + 5;
  localparam int SLOT_TOTAL   = SLOT_SENSOR0 + SENSOR_SLOTS;

  // Word kinds on the input channel
  localparam logic KIND_SLOT  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // Run control: extra cycles after the last byte, per-drain bound, whole-run
  // bound, long receiver hold-off
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_PRINTED   = 40;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Frame predictor: mirrors config, slot, sequence and running sum, and
  // holds the bytes the block still owes us, oldest first.
  class frame_predictor;
    logic [31:0]  sync_word;
    logic [3:0]   task_count;
    logic [7:0]   mode_safe;
    logic [7:0]   mode_nominal;
    int unsigned  slot;
    logic [31:0]  frame_seq;
    logic [15:0]  running_sum;
    frame_byte_t  expected_bytes[$];
    int           mismatches;
    int           bytes_checked;
    int           words_accepted;
    int           resets_accepted;
    int           frames_closed;

    function new();
      sync_word       = '0;
      task_count      = 4'd8;
      mode_safe       = 8'd1;
      mode_nominal    = 8'd0;
      slot            = SLOT_UPTIME;
      frame_seq       = '0;
      running_sum     = '0;
      mismatches      = 0;
      bytes_checked   = 0;
      words_accepted  = 0;
      resets_accepted = 0;
      frames_closed   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SYNC_WORD:    sync_word    = data;
        REG_TASK_COUNT:   task_count   = data[3:0];
        REG_MODE_SAFE:    mode_safe    = data[7:0];
        REG_MODE_NOMINAL: mode_nominal = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] sat16(logic [31:0] v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function logic [7:0] sat8(logic [31:0] v);
      return (v > 32'hFF) ? 8'hFF : v[7:0];
    endfunction

    function void queue_byte(logic [7:0] b, logic last);
      frame_byte_t e;
      e.data = b;
      e.last = last;
      expected_bytes.push_back(e);
    endfunction

    // Emit nbytes of v little-endian, folding each into the end-around-carry sum
    function void queue_summed(logic [31:0] v, int nbytes);
      logic [16:0] s;
      for (int i = 0; i < nbytes; i++) begin
        s = {1'b0, running_sum} + {9'd0, v[8*i +: 8]};
        running_sum = s[15:0] + {15'd0, s[16]};
        queue_byte(v[8*i +: 8], 1'b0);
      end
    endfunction

    // Note one accepted input word and work out the bytes it causes
    function void accept_word(logic k, logic [31:0] v, logic vv);
      logic [15:0] ck;
      words_accepted++;
      if (k == KIND_RESET) begin
        resets_accepted++;
        slot        = SLOT_UPTIME;
        frame_seq   = '0;
        running_sum = '0;
        return;
      end
      if (slot == SLOT_UPTIME) begin
        running_sum = '0;
        queue_summed(sync_word, 4);
        queue_summed(frame_seq, 4);
        queue_summed(vv ? v : 32'hFFFF_FFFF, 4);
      end else if (slot == SLOT_FRAMES) begin
        queue_summed(v, 4);
      end else if (slot == SLOT_FOVR || slot == SLOT_SLACK ||
                   (slot >= SLOT_REPAIRS && slot < SLOT_SHORT)) begin
        queue_summed(sat16(v), 2);
      end else if (slot >= SLOT_TASK0 && slot < SLOT_REPAIRS) begin
        queue_summed(((slot - SLOT_TASK0) < task_count) ? sat8(v) : 8'h00, 1);
      end else if (slot == SLOT_SHORT) begin
        queue_summed(sat8(v), 1);
      end else if (slot == SLOT_MODE) begin
        queue_summed((v != 0) ? mode_safe : mode_nominal, 1);
      end else if (slot < SLOT_SENSOR0) begin
        queue_summed(v[7:0], 1);
      end else begin
        queue_summed(v[15:0], 2);
      end
      slot++;
      if (slot >= SLOT_TOTAL) begin
        ck = running_sum ^ 16'hFFFF;
        queue_byte(ck[7:0], 1'b0);
        queue_byte(ck[15:8], 1'b1);
        frame_seq   = frame_seq + 1;
        running_sum = '0;
        slot        = SLOT_UPTIME;
        frames_closed++;
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Compare one accepted output byte against the oldest expectation
    task check_byte(logic [7:0] got, logic got_last);
      frame_byte_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %0d: got %02h last=%0b with nothing expected",
                         bytes_checked, got, got_last));
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want.data)
        report($sformatf("byte %0d: frame_byte %02h, expected %02h",
                         bytes_checked, got, want.data));
      if (got_last !== want.last)
        report($sformatf("byte %0d: last_of_frame %0b, expected %0b",
                         bytes_checked, got_last, want.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   kind;
  logic [31:0]            value;
  logic                   value_valid;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             frame_byte;
  logic                   last_of_frame;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  frame_predictor frames = new();

  // Idle control shared by the sender, the receiver and the phase sequencer
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_request = 1'b0;
  int hold_left;
  int cycles;

  telemetry_frame_packer #(
    .TASK_SLOTS  (TASK_SLOTS),
    .SENSOR_SLOTS(SENSOR_SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .value        (value),
    .value_valid  (value_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .last_of_frame(last_of_frame),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Slot values that sit on the saturation and masking boundaries often
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 255);
      3:       return $urandom_range(32'hFE, 32'h101);
      4:       return $urandom_range(32'hFFFE, 32'h1_0001);
      5:       return $urandom_range(0, 32'hFFFF);
      default: return $urandom();
    endcase
  endfunction

  // Hand-picked corners for one full directed frame, chosen by slot
  function automatic logic [31:0] corner_value(int s);
    case (s)
      SLOT_UPTIME: return 32'hDEAD_BEEF;   // sent with the clock marked failed
      SLOT_FRAMES: return 32'hFFFF_FFFF;
      SLOT_FOVR:   return 32'h0001_0000;
      SLOT_SLACK:  return 32'h0000_FFFF;
      SLOT_SHORT:  return 32'h0000_0100;
      SLOT_MODE:   return 32'h8000_0000;
      SLOT_REASON: return 32'hFFFF_FF5A;
      SLOT_CAUSE:  return 32'h0000_01FF;
      SLOT_FLAGS:  return 32'h0;
      default: begin
        case (s % 5)
          0:       return 32'hFFFF_FFFF;
          1:       return 32'h0001_0000;
          2:       return 32'h0000_FFFF;
          3:       return 32'h0000_0100;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // Offer one word and hold it until taken. Valid stays high between
  // back-to-back words; drop it only when a gap is inserted.
  task automatic send_word(logic k, logic [31:0] v, logic vv);
    int gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    value       <= v;
    value_valid <= vv;
    do @(posedge clk); while (!in_ready);
    frames.accept_word(k, v, vv);
  endtask

  // Mostly well-formed slot words; a few subsystem resets break frames apart
  task automatic send_random_word();
    if ($urandom_range(0, 99) < 3)
      send_word(KIND_RESET, $urandom(), 1'($urandom_range(0, 1)));
    else
      send_word(KIND_SLOT, random_value(), 1'($urandom_range(0, 9) != 0));
  endtask

  // Write all four registers on consecutive edges, then drop the enable
  task automatic program_regs(logic [31:0] w_sync, logic [31:0] w_tasks,
                              logic [31:0] w_safe, logic [31:0] w_nominal);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  words [4];
    idx   = '{REG_SYNC_WORD, REG_TASK_COUNT, REG_MODE_SAFE, REG_MODE_NOMINAL};
    words = '{w_sync, w_tasks, w_safe, w_nominal};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= words[i];
      @(posedge clk);
      frames.write_reg(idx[i], words[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Wait for every owed byte, then idle for SETTLE_CYCLES more.
  // Flag and flush anything that never shows up so the run can go on.
  task automatic settle();
    int waited;
    waited = 0;
    while (frames.expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (frames.expected_bytes.size() != 0) begin
      frames.report($sformatf("%0d expected bytes never arrived",
                              frames.expected_bytes.size()));
      frames.expected_bytes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration phase: program while idle, stream random words, drain.
  // Upper data bits above each narrow register carry noise the block must drop.
  task automatic run_phase(logic [31:0] sync, logic [3:0] tc, logic [7:0] safe,
                           logic [7:0] nominal, int count);
    logic [31:0] noise;
    noise = $urandom();
    program_regs(sync, {noise[31:4], tc}, {noise[31:8], safe}, {noise[31:8], nominal});
    for (int i = 0; i < count; i++) send_random_word();
    in_valid <= 1'b0;
    settle();
  endtask

  // Receiver: check each accepted byte, then pick the next ready level.
  // A long hold-off request overrides the random stalls.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) frames.check_byte(frame_byte, last_of_frame);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady) hold_left = gap_len();
      end
    end
  end

  // Watchdog: end the run if it goes far past any correct finish
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Watchdog expired after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_valid    <= 1'b0;
    kind        <= KIND_SLOT;
    value       <= '0;
    value_valid <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_SYNC_WORD;
    cfg_wdata   <= '0;
    rst         <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frame at reset config: failed clock read in the uptime slot,
    // saturation edges on the wide and byte counters, masking of the byte
    // and sensor slots, a safe mode value, checksum and sequence advance.
    for (int s = 0; s < SLOT_TOTAL; s++)
      send_word(KIND_SLOT, corner_value(s), (s == SLOT_UPTIME) ? 1'b0 : 1'b1);
    // Start a second frame with a good clock, then cut it with a reset word
    // and open a fresh frame whose sequence must be back at zero.
    send_word(KIND_SLOT, 32'h0, 1'b1);
    send_word(KIND_SLOT, 32'h0, 1'b0);
    send_word(KIND_SLOT, 32'hFFFF, 1'b0);
    send_word(KIND_RESET, 32'hFFFF_FFFF, 1'b1);
    send_word(KIND_SLOT, 32'hFFFF_FFFF, 1'b1);
    in_valid <= 1'b0;
    settle();

    // Back-pressure: the receiver holds off while the sender streams
    // without gaps, so the command queue fills and input stalls.
    tx_steady    = 1'b1;
    hold_request = 1'b1;
    run_phase(32'hFFFF_FFFF, 4'd15, 8'hFF, 8'h00, 75);
    tx_steady = 1'b0;

    // No live tasks, inverted mode codes
    run_phase(32'h0, 4'd0, 8'h00, 8'hFF, 75);
    run_phase($urandom(), 4'd3, 8'($urandom()), 8'($urandom()), 70);

    // Full rate on both sides at the reset mode codes
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_phase($urandom(), 4'd8, 8'h01, 8'h00, 70);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    run_phase($urandom(), 4'($urandom_range(1, 7)), 8'($urandom()), 8'($urandom()), 70);
    run_phase($urandom(), 4'($urandom_range(9, 14)), 8'($urandom()), 8'($urandom()), 70);

    $display("Run covered %0d input words (%0d subsystem resets), %0d frames closed",
             frames.words_accepted, frames.resets_accepted, frames.frames_closed);
    $display("Seven register settings, %0d output bytes compared, %0d mismatches",
             frames.bytes_checked, frames.mismatches);
    if (frames.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
